>>> rtl/fragment_reassembly_tracker_unit_macros.svh
// assertion helpers used by the tracker back end
`ifndef FRAGMENT_REASSEMBLY_TRACKER_UNIT_MACROS_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_UNIT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define FRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define FRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/frt_pkg.sv
package frt_pkg;

  localparam int unsigned SLOTS_DEF       = 4;
  localparam int unsigned MAX_PACKETS_DEF = 16;
  localparam int unsigned PKT_W           = 7;   // holds packet numbers up to 127
  localparam int unsigned QDEPTH          = 2;
  localparam int unsigned CAP             = 64;
  localparam int unsigned CAP_W           = 7;
  localparam int unsigned PCT_W           = 7;
  localparam logic [7:0]  HDR_RST         = 8'd16;
  localparam logic [15:0] SLACK_RST       = 16'd300;
  localparam logic [6:0]  PCT_FULL        = 7'd100;
  localparam logic [6:0]  PCT_MUL         = 7'd100;

  localparam logic [7:0]  CFG_HEADER = 8'd0;
  localparam logic [7:0]  CFG_SLACK  = 8'd1;

  typedef enum logic [1:0] {
    OP_DGRAM,
    OP_TICK,
    OP_REJECT
  } op_e;

  typedef enum logic [2:0] {
    KIND_COMPLETE,
    KIND_PROGRESS,
    KIND_MISSING,
    KIND_SHORT,
    KIND_BAD_NUMBER,
    KIND_SIZE,
    KIND_NO_SLOT,
    KIND_TOO_MANY
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_DIV,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    op_e              op;
    kind_e            kind;
    logic [31:0]      id;
    logic [PKT_W-1:0] pn;
    logic [PKT_W-1:0] tot;
    logic             file;
    logic [15:0]      ivl;
    logic [31:0]      addr;
    logic [15:0]      port;
  } entry_t;

  typedef struct packed {
    kind_e            kind;
    logic [31:0]      id;
    logic [15:0]      miss;
    logic [PCT_W-1:0] pct;
    logic [31:0]      addr;
    logic [15:0]      port;
    logic             last;
  } result_t;

endpackage

>>> rtl/frt_front.sv
module frt_front #(
  parameter int unsigned MAX_PACKETS = frt_pkg::MAX_PACKETS_DEF
) (
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [159:0]       s_axis_tdata,
  input  logic [1:0]         s_axis_tuser,
  input  logic [7:0]         header_bytes_i,
  input  logic               full_i,
  output logic               push_o,
  output frt_pkg::entry_t    entry_o
);
  import frt_pkg::*;

  logic [15:0] len, pn, tot, pay;
  logic [16:0] len_sum;
  logic        is_short, bad_num, bad_size, too_many;

  assign len     = s_axis_tdata[15:0];
  assign pn      = s_axis_tdata[63:48];
  assign tot     = s_axis_tdata[79:64];
  assign pay     = s_axis_tdata[95:80];
  assign len_sum = {9'd0, header_bytes_i} + {1'b0, pay};

  assign is_short = len < {8'd0, header_bytes_i};
  assign bad_num  = (pn == 16'd0) || (pn > tot);
  assign bad_size = {1'b0, len} != len_sum;
  assign too_many = tot > 16'(MAX_PACKETS);

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

  always_comb begin
    entry_o      = '0;
    entry_o.id   = s_axis_tdata[47:16];
    entry_o.pn   = pn[PKT_W-1:0];
    entry_o.tot  = tot[PKT_W-1:0];
    entry_o.file = s_axis_tuser[1];
    entry_o.ivl  = s_axis_tdata[111:96];
    entry_o.addr = s_axis_tdata[143:112];
    entry_o.port = s_axis_tdata[159:144];
    entry_o.op   = OP_REJECT;
    entry_o.kind = KIND_COMPLETE;
    priority if (s_axis_tuser[0]) begin
      entry_o.op = OP_TICK;
    end else if (is_short) begin
      entry_o.kind = KIND_SHORT;
      entry_o.id   = '0;
    end else if (bad_num) begin
      entry_o.kind = KIND_BAD_NUMBER;
    end else if (bad_size) begin
      entry_o.kind = KIND_SIZE;
    end else if (too_many) begin
      entry_o.kind = KIND_TOO_MANY;
    end else begin
      entry_o.op = OP_DGRAM;
    end
  end

endmodule

>>> rtl/frt_fifo.sv
module frt_fifo #(
  parameter int unsigned DEPTH = frt_pkg::QDEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  frt_pkg::entry_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output frt_pkg::entry_t data_o
);
  import frt_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> rtl/frt_back.sv
module frt_back #(
  parameter int unsigned SLOTS       = frt_pkg::SLOTS_DEF,
  parameter int unsigned MAX_PACKETS = frt_pkg::MAX_PACKETS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [15:0]      slack_i,
  input  logic             empty_i,
  input  frt_pkg::entry_t  entry_i,
  output logic             pop_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output frt_pkg::result_t res_o
);
  import frt_pkg::*;
  `include "fragment_reassembly_tracker_unit_macros.svh"

  localparam int unsigned TOT_W = $clog2(MAX_PACKETS + 1);
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned NUM_W = TOT_W + PCT_W;

  // slot table
  logic [SLOTS-1:0]       valid_q, valid_d, run_q, run_d, exp_q, exp_d;
  logic [31:0]            id_q   [SLOTS];
  logic [31:0]            id_d   [SLOTS];
  logic [TOT_W-1:0]       tot_q  [SLOTS];
  logic [TOT_W-1:0]       tot_d  [SLOTS];
  logic [15:0]            ivl_q  [SLOTS];
  logic [15:0]            ivl_d  [SLOTS];
  logic [MAX_PACKETS-1:0] map_q  [SLOTS];
  logic [MAX_PACKETS-1:0] map_d  [SLOTS];
  logic [TOT_W-1:0]       cnt_q  [SLOTS];
  logic [TOT_W-1:0]       cnt_d  [SLOTS];
  logic [16:0]            tmr_q  [SLOTS];
  logic [16:0]            tmr_d  [SLOTS];

  state_e           state_q, state_d;
  entry_t           cur_q, cur_d;
  logic [IDX_W-1:0] s_q, s_d;
  logic [TOT_W:0]   i_q, i_d;
  logic [CAP_W-1:0] n_q, n_d;
  result_t          pend_q, pend_d, out_q, out_d;
  logic             pend_v_q, pend_v_d, out_v_q, out_v_d;
  logic [TOT_W-1:0] rem_q, rem_d, div_q, div_d;
  logic [PCT_W-1:0] numlo_q, numlo_d, quo_q, quo_d;
  logic [2:0]       dcnt_q, dcnt_d;

  // lookup
  logic                   hit, free_ok;
  logic [IDX_W-1:0]       hit_idx, free_idx, sel;
  logic [TOT_W-1:0]       pn, tot_sel, cnt_old, cnt_new;
  logic [15:0]            ivl_sel;
  logic [MAX_PACKETS-1:0] map_old, bitv, map_new;
  logic                   no_slot, late_bad, done;
  logic [16:0]            tmr_new;
  logic [NUM_W-1:0]       num;

  // walk and divide
  logic                   can_emit, slot_end, is_miss, walk_stall;
  logic [MAX_PACKETS-1:0] walk_bits;
  logic [TOT_W:0]         div_sh;
  logic                   div_ge;

  assign can_emit    = !out_v_q || res_ready_i;
  assign res_valid_o = out_v_q;
  assign res_o       = out_q;
  assign pop_o       = (state_q == ST_IDLE) && !empty_i;

  always_comb begin
    hit      = 1'b0;
    free_ok  = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (valid_q[s] && id_q[s] == cur_q.id && !hit) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(s);
      end
      if (!valid_q[s] && !free_ok) begin
        free_ok  = 1'b1;
        free_idx = IDX_W'(s);
      end
    end
  end

  assign pn       = TOT_W'(cur_q.pn);
  assign sel      = hit ? hit_idx : free_idx;
  assign tot_sel  = hit ? tot_q[hit_idx] : TOT_W'(cur_q.tot);
  assign ivl_sel  = hit ? ivl_q[hit_idx] : cur_q.ivl;
  assign map_old  = hit ? map_q[hit_idx] : '0;
  assign cnt_old  = hit ? cnt_q[hit_idx] : '0;
  assign bitv     = MAX_PACKETS'(1) << (pn - 1'b1);
  assign map_new  = map_old | bitv;
  assign cnt_new  = (|(map_old & bitv)) ? cnt_old : cnt_old + 1'b1;
  assign done     = cnt_new >= tot_sel;
  assign no_slot  = !hit && !free_ok;
  assign late_bad = hit && (pn > tot_q[hit_idx]);
  assign tmr_new  = {1'b0, ivl_sel} + {1'b0, slack_i};
  assign num      = NUM_W'(cnt_new) * NUM_W'(PCT_MUL);

  assign walk_bits  = map_q[s_q] >> (i_q - 1'b1);
  assign slot_end   = !exp_q[s_q] || (i_q > {1'b0, tot_q[s_q]});
  assign is_miss    = !walk_bits[0] && (n_q < CAP_W'(CAP));
  assign walk_stall = !slot_end && is_miss && pend_v_q && !can_emit;

  assign div_sh = {rem_q, numlo_q[PCT_W-1]};
  assign div_ge = div_sh >= {1'b0, div_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (cur_q.op)
          OP_TICK: state_d = ST_WALK;
          OP_DGRAM: begin
            if (no_slot || late_bad || done) state_d = ST_FLUSH;
            else if (cur_q.file)             state_d = ST_DIV;
            else                             state_d = ST_IDLE;
          end
          default: state_d = ST_FLUSH;
        endcase
      end
      ST_WALK: begin
        if (slot_end && s_q == IDX_W'(SLOTS - 1)) state_d = ST_FLUSH;
      end
      ST_DIV: begin
        if (dcnt_q == 3'(PCT_W - 1)) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!pend_v_q || can_emit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    valid_d  = valid_q;
    run_d    = run_q;
    exp_d    = exp_q;
    id_d     = id_q;
    tot_d    = tot_q;
    ivl_d    = ivl_q;
    map_d    = map_q;
    cnt_d    = cnt_q;
    tmr_d    = tmr_q;
    cur_d    = cur_q;
    s_d      = s_q;
    i_d      = i_q;
    n_d      = n_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    out_d    = out_q;
    out_v_d  = out_v_q && !res_ready_i;
    rem_d    = rem_q;
    div_d    = div_q;
    numlo_d  = numlo_q;
    quo_d    = quo_q;
    dcnt_d   = dcnt_q;

    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) cur_d = entry_i;
      end
      ST_EXEC: begin
        pend_d      = '0;
        pend_d.id   = cur_q.id;
        pend_d.kind = cur_q.kind;
        pend_v_d    = 1'b1;
        unique case (cur_q.op)
          OP_TICK: begin
            // all running timers step down together
            for (int s = 0; s < SLOTS; s++) begin
              exp_d[s] = 1'b0;
              if (run_q[s]) begin
                tmr_d[s] = (tmr_q[s] != '0) ? tmr_q[s] - 1'b1 : '0;
                if (tmr_q[s] <= 17'd1) begin
                  run_d[s] = 1'b0;
                  exp_d[s] = 1'b1;
                end
              end
            end
            s_d      = '0;
            i_d      = (TOT_W+1)'(1);
            n_d      = '0;
            pend_v_d = 1'b0;
          end
          OP_DGRAM: begin
            priority if (no_slot) begin
              pend_d.kind = KIND_NO_SLOT;
            end else if (late_bad) begin
              pend_d.kind = KIND_BAD_NUMBER;
            end else begin
              if (!hit) begin
                id_d[sel]  = cur_q.id;
                tot_d[sel] = tot_sel;
                ivl_d[sel] = cur_q.ivl;
              end
              valid_d[sel] = 1'b1;
              map_d[sel]   = map_new;
              cnt_d[sel]   = cnt_new;
              tmr_d[sel]   = tmr_new;
              run_d[sel]   = 1'b1;
              if (done) begin
                valid_d[sel] = 1'b0;
                map_d[sel]   = '0;
                cnt_d[sel]   = '0;
                tmr_d[sel]   = '0;
                run_d[sel]   = 1'b0;
                pend_d.kind  = KIND_COMPLETE;
                pend_d.pct   = PCT_FULL;
                pend_d.addr  = cur_q.addr;
                pend_d.port  = cur_q.port;
              end else begin
                pend_d.kind = KIND_PROGRESS;
                pend_v_d    = cur_q.file;
                rem_d       = num[NUM_W-1:PCT_W];
                numlo_d     = num[PCT_W-1:0];
                div_d       = tot_sel;
                quo_d       = '0;
                dcnt_d      = '0;
              end
            end
          end
          default: ;
        endcase
      end
      ST_WALK: begin
        if (slot_end) begin
          s_d = (s_q == IDX_W'(SLOTS - 1)) ? s_q : s_q + 1'b1;
          i_d = (TOT_W+1)'(1);
        end else if (!walk_stall) begin
          if (is_miss) begin
            if (pend_v_q) begin
              out_d      = pend_q;
              out_d.last = 1'b0;
              out_v_d    = 1'b1;
            end
            pend_d      = '0;
            pend_d.kind = KIND_MISSING;
            pend_d.id   = id_q[s_q];
            pend_d.miss = 16'(i_q);
            pend_v_d    = 1'b1;
            n_d         = n_q + 1'b1;
          end
          i_d = i_q + 1'b1;
        end
      end
      ST_DIV: begin
        rem_d   = div_ge ? TOT_W'(div_sh - {1'b0, div_q}) : TOT_W'(div_sh);
        numlo_d = numlo_q << 1;
        quo_d   = {quo_q[PCT_W-2:0], div_ge};
        dcnt_d  = dcnt_q + 1'b1;
        if (dcnt_q == 3'(PCT_W - 1)) pend_d.pct = {quo_q[PCT_W-2:0], div_ge};
      end
      ST_FLUSH: begin
        if (pend_v_q && can_emit) begin
          out_d      = pend_q;
          out_d.last = 1'b1;
          out_v_d    = 1'b1;
          pend_v_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid_q  <= '0;
      run_q    <= '0;
      exp_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      n_q      <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        map_q[s] <= '0;
        cnt_q[s] <= '0;
        tmr_q[s] <= '0;
      end
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      run_q    <= run_d;
      exp_q    <= exp_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      n_q      <= n_d;
      map_q    <= map_d;
      cnt_q    <= cnt_d;
      tmr_q    <= tmr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    tot_q   <= tot_d;
    ivl_q   <= ivl_d;
    cur_q   <= cur_d;
    s_q     <= s_d;
    i_q     <= i_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
    rem_q   <= rem_d;
    div_q   <= div_d;
    numlo_q <= numlo_d;
    quo_q   <= quo_d;
    dcnt_q  <= dcnt_d;
  end

  `FRT_ASSERT(a_run_needs_valid, (run_q & ~valid_q) == '0, "timer running on free slot")
  `FRT_ASSERT(a_count_matches_map, $countones(map_q[0]) == int'(cnt_q[0]),
              "slot count differs from received map")
  `FRT_ASSERT(a_cap_bound, n_q <= CAP_W'(CAP), "missing result count beyond cap")
  `FRT_ASSERT_NEXT(a_out_held, out_v_q && !res_ready_i, out_v_q, "result lost while stalled")

endmodule

>>> rtl/fragment_reassembly_tracker_unit.sv
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+--------------------------------------
// s_axis    | in        | s_axis_tvalid/tready      | datagram header fields or a tick
// m_axis    | out       | m_axis_tvalid/tready      | result record, tlast on final result
// cfg       | in        | cfg_valid_i/cfg_ready_o   | register index and write data
//
// a datagram in the execute unit is popped, updates its slot and sends a result, if it has one
// a file progress result also passes through the bit-serial percent divider
// a tick steps all running timers, then walks each slot and each packet number of each expired slot
// the front classifies and queues up to 2 items while the execute unit works
// reset is asynchronous active low and clears the slot table at once, no sweep
// a stalled result output holds the walk; config writes are always accepted (cfg_ready_o is tied high)
module fragment_reassembly_tracker_unit #(
  parameter int unsigned SLOTS       = frt_pkg::SLOTS_DEF,
  parameter int unsigned MAX_PACKETS = frt_pkg::MAX_PACKETS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // tdata: datagram_length, message_id, packet_number, total_packets, payload_size,
  //        packet_interval, sender_address, sender_port
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,
  // tuser: command, is_file
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: result_message_id, missing_number, progress_percent, out_address,
  //        out_port, one pad bit
  output logic [103:0] m_axis_tdata,
  // tuser: kind
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);
  import frt_pkg::*;

  // configuration registers
  logic [7:0]  hdr_q, hdr_d;
  logic [15:0] slack_q, slack_d;

  // front to queue to execute unit
  logic    push, full, pop, empty;
  entry_t  q_in, q_out;
  result_t res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    hdr_d   = hdr_q;
    slack_d = slack_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_HEADER) hdr_d   = cfg_data_i[7:0];
      if (cfg_index_i == CFG_SLACK)  slack_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q   <= HDR_RST;
      slack_q <= SLACK_RST;
    end else begin
      hdr_q   <= hdr_d;
      slack_q <= slack_d;
    end
  end

  // classification of incoming transactions, no slot state needed
  frt_front #(
    .MAX_PACKETS(MAX_PACKETS)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .header_bytes_i(hdr_q),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (q_in)
  );

  // short queue so the front keeps taking items while the back is busy
  frt_fifo #(
    .DEPTH(QDEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_in),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (q_out)
  );

  // slot table, timer walk and percent divider
  frt_back #(
    .SLOTS      (SLOTS),
    .MAX_PACKETS(MAX_PACKETS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .slack_i    (slack_q),
    .empty_i    (empty),
    .entry_i    (q_out),
    .pop_o      (pop),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {1'b0, res.port, res.addr, res.pct, res.miss, res.id};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

>>> sim/tb_fragment_reassembly_tracker_unit.sv
`timescale 1ns / 1ps

module tb_fragment_reassembly_tracker_unit;
  import frt_pkg::*;

  localparam int unsigned NSLOT = 4;
  localparam int unsigned NPKT  = 16;
  localparam int unsigned CMD_DGRAM = 0;
  localparam int unsigned CMD_TICK  = 1;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  // one expected result transaction
  typedef struct {
    kind_e       kind;
    logic [31:0] id;
    logic [15:0] miss;
    logic [6:0]  pct;
    logic [31:0] addr;
    logic [15:0] port;
    logic        last;
  } tracker_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [103:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [7:0]   cfg_index_i;
  logic [15:0]  cfg_data_i;

  fragment_reassembly_tracker_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // predictor state
  logic [7:0]  hdr_bytes;
  logic [15:0] slack;
  logic        sv_valid   [NSLOT];
  logic [31:0] sv_id      [NSLOT];
  logic [15:0] sv_total   [NSLOT];
  logic [15:0] sv_map     [NSLOT];
  logic [4:0]  sv_count   [NSLOT];
  logic [15:0] sv_ivl     [NSLOT];
  logic [16:0] sv_timer   [NSLOT];
  logic        sv_running [NSLOT];

  tracker_result_t expected_results[$];
  int unsigned mismatches;
  bit          timed_out;
  bit          hold_off;     // long receiver stall requested
  int unsigned hold_cycles;
  int unsigned rx_wait;      // idle cycles before taking the next result
  longint unsigned cycle_cnt;

  // recently used ids so random datagrams hit live slots
  logic [31:0] id_pool[$];

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void push_result(kind_e k, logic [31:0] id, logic [15:0] miss,
                                      logic [6:0] pct, logic [31:0] addr,
                                      logic [15:0] port);
    tracker_result_t r;
    r.kind = k; r.id = id; r.miss = miss; r.pct = pct;
    r.addr = addr; r.port = port; r.last = 1'b0;
    expected_results.push_back(r);
  endfunction

  function automatic void reset_tracker_model();
    hdr_bytes = HDR_RST;
    slack     = SLACK_RST;
    for (int s = 0; s < NSLOT; s++) begin
      sv_valid[s] = 0; sv_id[s] = 0; sv_total[s] = 0; sv_map[s] = 0;
      sv_count[s] = 0; sv_ivl[s] = 0; sv_timer[s] = 0; sv_running[s] = 0;
    end
  endfunction

  // count timers down, report missing numbers of expired slots
  function automatic int predict_tick();
    int n;
    n = 0;
    for (int s = 0; s < NSLOT; s++) begin
      if (!sv_running[s]) continue;
      if (sv_timer[s] > 0) sv_timer[s]--;
      if (sv_timer[s] != 0) continue;
      sv_running[s] = 1'b0;
      for (int i = 1; i <= sv_total[s] && i <= NPKT; i++) begin
        if (sv_map[s][i-1]) continue;
        if (n < CAP) begin
          push_result(KIND_MISSING, sv_id[s], 16'(i), '0, '0, '0);
          n++;
        end
      end
    end
    return n;
  endfunction

  function automatic int predict_datagram(logic [15:0] len, logic [31:0] id,
                                          logic [15:0] pn, logic [15:0] tot,
                                          logic [15:0] pay, logic file,
                                          logic [15:0] ivl, logic [31:0] addr,
                                          logic [15:0] port);
    int hit, freeidx;
    hit = -1;
    freeidx = -1;
    if (len < hdr_bytes) begin
      push_result(KIND_SHORT, '0, '0, '0, '0, '0);
      return 1;
    end
    if (pn == 0 || pn > tot) begin
      push_result(KIND_BAD_NUMBER, id, '0, '0, '0, '0);
      return 1;
    end
    if (17'(len) != 17'(hdr_bytes) + 17'(pay)) begin
      push_result(KIND_SIZE, id, '0, '0, '0, '0);
      return 1;
    end
    if (tot > NPKT) begin
      push_result(KIND_TOO_MANY, id, '0, '0, '0, '0);
      return 1;
    end
    for (int s = 0; s < NSLOT; s++) begin
      if (sv_valid[s] && sv_id[s] == id && hit < 0) hit = s;
      if (!sv_valid[s] && freeidx < 0) freeidx = s;
    end
    if (hit < 0) begin
      if (freeidx < 0) begin
        push_result(KIND_NO_SLOT, id, '0, '0, '0, '0);
        return 1;
      end
      hit = freeidx;
      sv_valid[hit] = 1; sv_id[hit] = id; sv_total[hit] = tot;
      sv_ivl[hit] = ivl; sv_map[hit] = 0; sv_count[hit] = 0;
    end else if (pn > sv_total[hit]) begin
      push_result(KIND_BAD_NUMBER, id, '0, '0, '0, '0);
      return 1;
    end
    sv_timer[hit]   = 17'(sv_ivl[hit]) + 17'(slack);
    sv_running[hit] = 1'b1;
    if (!sv_map[hit][pn-1]) begin
      sv_map[hit][pn-1] = 1'b1;
      sv_count[hit]++;
    end
    if (sv_count[hit] >= sv_total[hit]) begin
      sv_valid[hit] = 0; sv_map[hit] = 0; sv_count[hit] = 0;
      sv_timer[hit] = 0; sv_running[hit] = 0;
      push_result(KIND_COMPLETE, id, '0, PCT_FULL, addr, port);
      return 1;
    end
    if (file) begin
      push_result(KIND_PROGRESS, id, '0, 7'((32'(sv_count[hit]) * 100) / sv_total[hit]),
                  '0, '0);
      return 1;
    end
    return 0;
  endfunction

  // drive one item, predict it at acceptance
  task automatic send_item(logic cmd, logic [15:0] len, logic [31:0] id, logic [15:0] pn,
                           logic [15:0] tot, logic [15:0] pay, logic file,
                           logic [15:0] ivl, logic [31:0] addr, logic [15:0] port,
                           bit no_gap = 0);
    int n;
    if (!no_gap) repeat ($urandom_range(0, 8)) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {port, addr, ivl, pay, tot, pn, id, len};
    s_axis_tuser  = {file, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd == 1'(CMD_TICK)) n = predict_tick();
    else n = predict_datagram(len, id, pn, tot, pay, file, ivl, addr, port);
    if (n > 0) expected_results[$].last = 1'b1;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic send_tick();
    send_item(1'(CMD_TICK), 16'($urandom), $urandom, 16'($urandom), 16'($urandom),
              16'($urandom), 1'($urandom), 16'($urandom), $urandom, 16'($urandom));
  endtask

  // well-formed datagram built from current header setting
  task automatic send_good(logic [31:0] id, logic [15:0] pn, logic [15:0] tot,
                           logic file, logic [15:0] ivl, bit no_gap = 0);
    logic [15:0] pay;
    pay = 16'($urandom_range(0, 65535 - hdr_bytes));
    send_item(1'(CMD_DGRAM), 16'(hdr_bytes + pay), id, pn, tot, pay, file, ivl,
              $urandom, 16'($urandom), no_gap);
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  // send the missing packets of every open slot so the table is empty again
  task automatic clear_slots();
    logic [31:0] id;
    logic [15:0] tot;
    for (int s = 0; s < NSLOT; s++) begin
      id  = sv_id[s];
      tot = sv_total[s];
      for (int p = 1; p <= tot; p++)
        if (sv_valid[s] && sv_id[s] == id && !sv_map[s][p-1])
          send_good(id, 16'(p), tot, 1'b0, 16'd0);
    end
    wait_drained();
  endtask

  task automatic write_cfg(logic [7:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_HEADER) hdr_bytes = val[7:0];
    else if (idx == CFG_SLACK) slack = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // result side: random wait per result, plus long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off) begin
      m_axis_tready <= 1'b0;
      if (hold_cycles == 0) hold_off = 1'b0;
      else hold_cycles--;
    end else if (rx_wait != 0) begin
      m_axis_tready <= 1'b0;
      rx_wait--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // checker on each accepted result transaction
  always @(posedge clk_i) begin
    tracker_result_t e;
    tracker_result_t a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      a.id   = m_axis_tdata[31:0];
      a.miss = m_axis_tdata[47:32];
      a.pct  = m_axis_tdata[54:48];
      a.addr = m_axis_tdata[86:55];
      a.port = m_axis_tdata[102:87];
      a.kind = kind_e'(m_axis_tuser);
      a.last = m_axis_tlast;
      rx_wait = $urandom_range(0, 8);
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind=%0d id=%h", a.kind, a.id);
      end else begin
        e = expected_results.pop_front();
        if (e.kind !== a.kind || e.id !== a.id || e.miss !== a.miss || e.pct !== a.pct ||
            e.addr !== a.addr || e.port !== a.port || e.last !== a.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch exp k=%0d id=%h m=%0d p=%0d a=%h pt=%h l=%b",
                     e.kind, e.id, e.miss, e.pct, e.addr, e.port, e.last);
            $display("                act k=%0d id=%h m=%0d p=%0d a=%h pt=%h l=%b",
                     a.kind, a.id, a.miss, a.pct, a.addr, a.port, a.last);
          end
        end
      end
    end
  end

  // field extremes and every front-end drop reason
  task automatic test_drop_reasons();
    send_item(1'(CMD_DGRAM), 16'd0, '1, 16'd1, 16'd1, 16'd0, 1'b0, '0, '0, '0);
    send_item(1'(CMD_DGRAM), 16'd15, 32'h1, 16'd1, 16'd1, 16'd0, 1'b0, '0, '0, '0);
    send_item(1'(CMD_DGRAM), 16'd16, 32'h2, 16'd0, 16'd3, 16'd0, 1'b1, '0, '0, '0);
    send_item(1'(CMD_DGRAM), 16'd16, 32'h3, 16'd4, 16'd3, 16'd0, 1'b0, '0, '0, '0);
    send_item(1'(CMD_DGRAM), '1, '1, '1, '1, '1, 1'b1, '1, '1, '1);
    send_item(1'(CMD_DGRAM), 16'd20, 32'h4, 16'd1, 16'd2, 16'd5, 1'b0, '0, '0, '0);
    send_item(1'(CMD_DGRAM), 16'd16, 32'h5, 16'd17, 16'd17, 16'd0, 1'b0, '0, '0, '0);
    send_item(1'(CMD_DGRAM), 16'd16, 32'h6, 16'd1, '1, 16'd0, 1'b0, '0, '0, '0);
  endtask

  // completion, progress, duplicates, stored total, no slot
  task automatic test_reassembly();
    send_good(32'hA, 16'd1, 16'd1, 1'b0, 16'd0);
    send_good(32'hB, 16'd1, 16'd3, 1'b1, 16'd10);
    send_good(32'hB, 16'd1, 16'd3, 1'b1, 16'd10);       // duplicate
    send_good(32'hB, 16'd5, 16'd9, 1'b1, 16'd10);       // beyond stored total
    send_good(32'hB, 16'd2, 16'd3, 1'b0, 16'd10);       // non-file incomplete
    send_good(32'hB, 16'd3, 16'd3, 1'b1, 16'd10);
    send_good(32'hC, 16'd16, 16'd16, 1'b1, '1);
    send_good(32'hD, 16'd2, 16'd2, 1'b0, 16'd0);
    send_good(32'hE, 16'd1, 16'd2, 1'b0, 16'd0);
    send_good(32'hF, 16'd1, 16'd2, 1'b0, 16'd0);
    send_good(32'h10, 16'd1, 16'd2, 1'b0, 16'd0);       // table full
    wait_drained();
  endtask

  // expiry with minimum timeout, then zero timeout
  task automatic test_timeouts();
    clear_slots();
    write_cfg(CFG_SLACK, 16'd1);
    send_good(32'h21, 16'd1, 16'd3, 1'b0, 16'd0);
    send_tick();
    send_tick();
    wait_drained();
    write_cfg(CFG_SLACK, 16'd0);
    send_good(32'h20, 16'd1, 16'd4, 1'b0, 16'd0);
    send_tick();
    send_tick();
    wait_drained();
  endtask

  // every slot expiring on the same tick
  task automatic test_mass_expiry();
    clear_slots();
    write_cfg(CFG_SLACK, 16'd2);
    for (int s = 0; s < NSLOT; s++)
      send_good(32'h30 + s, 16'd1, 16'd8 - 16'(s[0]), 1'b0, '0);
    wait_drained();
    send_tick();
    send_tick();
    send_tick();
    wait_drained();
    // expired slots stay valid, complete them to free the table
    clear_slots();
  endtask

  // random traffic, mostly well-formed messages over a small id pool
  task automatic test_random_traffic(int unsigned n_items);
    logic [31:0] id;
    logic [15:0] tot;
    int unsigned pick;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_tick();
      end else if (pick < 80) begin
        id = (id_pool.size() != 0 && $urandom_range(0, 3) != 0) ?
             id_pool[$urandom_range(0, id_pool.size() - 1)] : $urandom;
        if (id_pool.size() < 6) id_pool.push_back(id);
        tot = 16'($urandom_range(1, 5));
        for (int s = 0; s < NSLOT; s++) if (sv_valid[s] && sv_id[s] == id) tot = sv_total[s];
        send_good(id, 16'($urandom_range(1, tot)), tot, 1'($urandom),
                  16'($urandom_range(0, 3)));
      end else if (pick < 85) begin
        send_good($urandom, 16'($urandom_range(1, 16)), 16'd16, 1'($urandom),
                  16'($urandom));
      end else begin
        send_item(1'(CMD_DGRAM), 16'($urandom), $urandom, 16'($urandom), 16'($urandom),
                  16'($urandom), 1'($urandom), 16'($urandom), $urandom, 16'($urandom));
      end
      if (id_pool.size() >= 6 && $urandom_range(0, 9) == 0) void'(id_pool.pop_front());
    end
    wait_drained();
  endtask

  // receiver blocked while the sender keeps offering
  task automatic test_backpressure();
    hold_cycles = 400;
    hold_off    = 1'b1;
    for (int i = 0; i < 12; i++)
      send_item(1'(CMD_DGRAM), 16'd0, $urandom, '1, '1, '1, 1'b1, '1, '1, '1, 1);
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    mismatches    = 0;
    timed_out     = 0;
    hold_off      = 0;
    hold_cycles   = 0;
    rx_wait       = 0;
    cycle_cnt     = 0;
    reset_tracker_model();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_drop_reasons();
    test_reassembly();
    test_timeouts();
    test_mass_expiry();
    test_backpressure();
    write_cfg(CFG_HEADER, 8'd1);
    write_cfg(CFG_SLACK, 16'd3);
    test_random_traffic(40);
    write_cfg(CFG_HEADER, 8'd255);
    write_cfg(CFG_SLACK, 16'd65535);
    test_random_traffic(30);
    write_cfg(CFG_HEADER, 8'd20);
    write_cfg(CFG_SLACK, 16'd6);
    test_random_traffic(40);

    wait_drained();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
